### rtl/fpp_pkg.sv
// Shared types and constants for the float to PCM frame packer.
`timescale 1ns / 1ps
package fpp_pkg;

  typedef enum logic [2:0] {
    FMT_F32 = 3'd0,
    FMT_U8  = 3'd1,
    FMT_U16 = 3'd2,
    FMT_U24 = 3'd3,
    FMT_S8  = 3'd4,
    FMT_S16 = 3'd5,
    FMT_S24 = 3'd6,
    FMT_S32 = 3'd7
  } fmt_t;

  typedef enum logic [0:0] {
    REG_FORMAT   = 1'b0,
    REG_CHANNELS = 1'b1
  } reg_idx_t;

  localparam logic [31:0] ONE_F = 32'h3F80_0000;

  // One converted word as it leaves the front part.
  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  nbytes;
  } conv_t;

  // Number of valid bytes of a format; float32 and s32 both use four.
  function automatic logic [2:0] fmt_bytes(input fmt_t f);
    logic [2:0] b;
    unique case (f)
      FMT_U8, FMT_S8:   b = 3'd1;
      FMT_U16, FMT_S16: b = 3'd2;
      FMT_U24, FMT_S24: b = 3'd3;
      default:          b = 3'd4;
    endcase
    return b;
  endfunction

endpackage

### rtl/float_to_pcm_frame_packer.sv
// Top level of the float to PCM frame packer.
`timescale 1ns / 1ps
// Converts one IEEE single-precision mono sample per transaction into a PCM
// word in the format chosen by sample_format, then emits that word once per
// channel (channel_count, zero taken as one, capped at MAX_CHANNELS), with
// last_channel on the final word. A sample enters when start is high and busy
// is low. The conversion pipeline feeds a four-entry queue; the channel
// emitter drains one word per cycle while the queue is not empty, and pops
// a sample with its last channel's word. Words reach the result ports from
// the emitter's output register. busy rises when the queue could overflow,
// counting the entry the emitter frees in the same cycle. Results appear
// for one cycle with out_valid and cannot be held.
module float_to_pcm_frame_packer #(
  parameter int MAX_CHANNELS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] sample_bits,
  output logic        out_valid,
  output logic [31:0] pcm_word,
  output logic [2:0]  byte_count,
  output logic        last_channel
);
  localparam int QD = 4;
  localparam int CW = $clog2(MAX_CHANNELS + 1);

  fpp_pkg::fmt_t sample_format;
  logic [3:0]    channel_count;
  logic          wr;
  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_format <= fpp_pkg::FMT_S16;
      channel_count <= 4'd2;
    end else if (wr && paddr[1:0] == 2'b00) begin
      if (paddr[2] == fpp_pkg::REG_FORMAT) sample_format <= fpp_pkg::fmt_t'(pwdata[2:0]);
      else channel_count <= pwdata[3:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[1:0] == 2'b00) begin
      if (paddr[2] == fpp_pkg::REG_FORMAT) prdata = {29'd0, sample_format};
      else prdata = {28'd0, channel_count};
    end
  end

  // Effective channel count.
  logic [CW-1:0] nchan;
  always_comb begin
    if (channel_count == 4'd0) nchan = CW'(1);
    else if (32'(channel_count) > MAX_CHANNELS) nchan = CW'(MAX_CHANNELS);
    else nchan = CW'(channel_count);
  end

  logic           accept, cv_valid, avail, take;
  fpp_pkg::conv_t cv_data, q_data;
  logic [$clog2(QD+1)-1:0] fill;
  logic [2:0]     inflight;

  assign accept = start && !busy;

  fpp_convert u_conv (
    .clk, .rst, .in_valid(accept), .sample_bits, .fmt(sample_format),
    .out_valid(cv_valid), .out_data(cv_data)
  );

  fpp_queue #(.DEPTH(QD)) u_q (
    .clk, .rst, .wr_en(cv_valid), .wr_data(cv_data), .rd_en(take),
    .not_empty(avail), .rd_data(q_data), .fill
  );

  fpp_emit #(.CW(CW)) u_emit (
    .clk, .rst, .avail, .data(q_data), .nchan, .take, .strobe(out_valid),
    .pcm_word, .byte_count, .last_channel
  );

  // Items inside the three-stage pipeline.
  always_ff @(posedge clk) begin
    if (rst) inflight <= '0;
    else inflight <= inflight + (accept ? 3'd1 : 3'd0) - (cv_valid ? 3'd1 : 3'd0);
  end
  // A queue entry read out at this edge is free for a sample accepted now.
  assign busy = (32'(fill) + 32'(inflight)) >= (32'(QD) + 32'(take));

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(cv_valid && fill == QD[$clog2(QD+1)-1:0] && !take)) else $error("queue overflow");
  a_take_last: assert property (@(posedge clk) disable iff (rst)
    take |=> out_valid && last_channel) else $error("take without last word");
  a_inflight: assert property (@(posedge clk) disable iff (rst)
    inflight <= 3'd3) else $error("pipeline count wrong");
`endif
endmodule

### rtl/fpp_convert.sv
// Front part: clamps and quantizes one float sample to the configured PCM format.
`timescale 1ns / 1ps
module fpp_convert (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [31:0]        sample_bits,
  input  fpp_pkg::fmt_t      fmt,
  output logic               out_valid,
  output fpp_pkg::conv_t     out_data
);

  // Stage 1: clamp, then form the multiplier operand as a single-precision
  // significand and biased exponent. Signed formats use x itself; unsigned
  // formats use u = x + 1, rounded to single precision like the float add.
  logic          s1_valid;
  fpp_pkg::fmt_t s1_fmt;
  logic [31:0]   s1_xbits;
  logic          s1_neg;
  logic [23:0]   s1_mant;
  logic [7:0]    s1_exp;

  logic [31:0] xb;
  logic [7:0]  e;
  logic [22:0] f;
  logic        isnan, big;
  logic [23:0] sig;
  logic [7:0]  rsh;
  logic [47:0] fx;       // |x| with 46 fraction bits
  logic        sticky_x; // nonzero bits of |x| below 2^-46
  logic [47:0] ufx;      // 1 +/- |x| with 46 fraction bits
  logic [5:0]  lz;
  logic [47:0] un;
  logic        ug, us;
  logic [24:0] ur;
  logic [23:0] umant;
  logic [7:0]  uexp;

  always_comb begin
    e     = sample_bits[30:23];
    f     = sample_bits[22:0];
    isnan = (e == 8'hFF) && (f != 23'd0);
    big   = (e > 8'd127) || ((e == 8'd127) && (f != 23'd0));
    if (isnan)    xb = 32'd0;
    else if (big) xb = {sample_bits[31], fpp_pkg::ONE_F[30:0]};
    else          xb = sample_bits;
    sig = (xb[30:23] == 8'd0) ? {1'b0, xb[22:0]} : {1'b1, xb[22:0]};
    // |x| = sig * 2^(e-150); at 46 fraction bits that is a shift by e-104.
    rsh = 8'd0;
    if (xb[30:23] >= 8'd104) begin
      fx = {24'd0, sig} << (xb[30:23] - 8'd104);
      sticky_x = 1'b0;
    end else begin
      rsh = 8'd104 - xb[30:23];
      fx = {24'd0, sig} >> rsh;
      if (rsh >= 8'd24) sticky_x = (sig != 24'd0);
      else sticky_x = ((sig & ((24'd1 << rsh) - 24'd1)) != 24'd0);
    end
    // A negative operand with lost low bits lies just below 1 - fx, so one
    // unit comes off and the sticky bit marks the remainder.
    if (xb[31]) ufx = (48'd1 << 46) - fx - {47'd0, sticky_x};
    else        ufx = (48'd1 << 46) + fx;
    lz = 6'd0;
    for (int i = 0; i < 48; i++) if (ufx[i]) lz = 6'(47 - i);
    // Round u to 24 significant bits, ties to even.
    un = ufx << lz;
    ug = un[23];
    us = (|un[22:0]) | sticky_x;
    ur = {1'b0, un[47:24]} + {24'd0, ug & (us | un[24])};
    if (ufx == 48'd0) begin
      umant = 24'd0;
      uexp  = 8'd0;
    end else if (ur[24]) begin
      umant = 24'h80_0000;
      uexp  = 8'd129 - {2'd0, lz};
    end else begin
      umant = ur[23:0];
      uexp  = 8'd128 - {2'd0, lz};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else     s1_valid <= in_valid;
    s1_fmt   <= fmt;
    s1_xbits <= xb;
    if (fmt == fpp_pkg::FMT_U8 || fmt == fpp_pkg::FMT_U16 || fmt == fpp_pkg::FMT_U24) begin
      s1_neg  <= 1'b0;
      s1_mant <= umant;
      s1_exp  <= uexp;
    end else begin
      s1_neg  <= xb[31];
      s1_mant <= sig;
      s1_exp  <= xb[30:23];
    end
  end

  // Stage 2: single-precision multiply by the format's scale (24x24 bits); stage 3
  // rounds the product to single, then to integer ties to even.
  logic [23:0] scale_m;
  logic [7:0]  scale_e;
  always_comb begin
    unique case (s1_fmt)
      fpp_pkg::FMT_U8:  begin scale_m = 24'hFF0000; scale_e = 8'd133; end // 127.5
      fpp_pkg::FMT_U16: begin scale_m = 24'hFFFF00; scale_e = 8'd141; end // 32767.5
      fpp_pkg::FMT_U24: begin scale_m = 24'hFFFFFF; scale_e = 8'd149; end // 8388607.5
      fpp_pkg::FMT_S8:  begin scale_m = 24'hFE0000; scale_e = 8'd133; end // 127
      fpp_pkg::FMT_S24: begin scale_m = 24'hFFFFFE; scale_e = 8'd149; end // 8388607
      fpp_pkg::FMT_S32: begin scale_m = 24'h800000; scale_e = 8'd158; end // 2^31
      default:          begin scale_m = 24'hFFFE00; scale_e = 8'd141; end // 32767
    endcase
  end

  logic [47:0] prod;
  logic        s2_valid;
  fpp_pkg::fmt_t s2_fmt;
  logic [31:0] s2_xbits;
  logic        s2_neg;
  logic [47:0] s2_prod;
  logic [9:0]  s2_exp;
  logic        s2_zero;

  assign prod = s1_mant * scale_m;

  always_ff @(posedge clk) begin
    if (rst) s2_valid <= 1'b0;
    else     s2_valid <= s1_valid;
    s2_fmt   <= s1_fmt;
    s2_xbits <= s1_xbits;
    s2_neg   <= s1_neg;
    s2_prod  <= prod;
    s2_exp   <= {2'd0, s1_exp} + {2'd0, scale_e};
    s2_zero  <= (s1_mant == 24'd0);
  end

  // Stage 3 logic: normalize product to 24 bits (single rounding), then to integer.
  logic [47:0] pn;
  logic [9:0]  pe;
  logic [23:0] pm;
  logic [24:0] pm_r;
  logic [5:0]  sh;
  logic [63:0] ival_fx;  // value with 30 fraction bits
  logic [33:0] ipart;
  logic [29:0] frac;
  logic [33:0] iround;
  logic signed [34:0] sval;
  logic signed [34:0] lo, hi;
  logic [31:0] word;
  logic        g, st;
  always_comb begin
    // Subnormal operands have no leading one; their product is far below one half.
    if (s2_prod[47]) begin pn = s2_prod;        pe = s2_exp - 10'd126; end
    else             begin pn = s2_prod << 1;   pe = s2_exp - 10'd127; end
    g  = pn[23];
    st = |pn[22:0];
    pm_r = {1'b0, pn[47:24]} + {24'd0, g & (st | pn[24])};
    pm = pm_r[24] ? pm_r[24:1] : pm_r[23:0];
    if (pm_r[24]) pe = pe + 10'd1;
    // value = pm * 2^(pe - 150); with 30 fraction bits that is pm << (pe - 120).
    // Below that exponent the value is far under one half and rounds to zero.
    ival_fx = '0;
    sh = '0;
    if (!s2_zero && pe >= 10'd120) begin
      sh = 6'(pe - 10'd120);
      ival_fx = {40'd0, pm} << sh;
    end
    ipart = ival_fx[63:30];
    frac  = ival_fx[29:0];
    iround = ipart;
    if (frac[29] && ((|frac[28:0]) || ipart[0])) iround = ipart + 34'd1;
    sval = s2_neg ? -$signed({1'b0, iround}) : $signed({1'b0, iround});
    unique case (s2_fmt)
      fpp_pkg::FMT_U8:  begin lo = 35'sd0; hi = 35'sd255; end
      fpp_pkg::FMT_U16: begin lo = 35'sd0; hi = 35'sd65535; end
      fpp_pkg::FMT_U24: begin lo = 35'sd0; hi = 35'sd16777215; end
      fpp_pkg::FMT_S8:  begin lo = -35'sd128; hi = 35'sd127; end
      fpp_pkg::FMT_S24: begin lo = -35'sd8388608; hi = 35'sd8388607; end
      fpp_pkg::FMT_S32: begin lo = -35'sd2147483648; hi = 35'sd2147483647; end
      default:          begin lo = -35'sd32768; hi = 35'sd32767; end
    endcase
    if (sval < lo) sval = lo;
    if (sval > hi) sval = hi;
    unique case (fpp_pkg::fmt_bytes(s2_fmt))
      3'd1:    word = {24'd0, sval[7:0]};
      3'd2:    word = {16'd0, sval[15:0]};
      3'd3:    word = {8'd0, sval[23:0]};
      default: word = sval[31:0];
    endcase
    if (s2_fmt == fpp_pkg::FMT_F32) word = s2_xbits;
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else     out_valid <= s2_valid;
    out_data.word   <= word;
    out_data.nbytes <= fpp_pkg::fmt_bytes(s2_fmt);
  end

endmodule

### rtl/fpp_queue.sv
// Small FIFO between the conversion front part and the channel emitter.
`timescale 1ns / 1ps
module fpp_queue #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_en,
  input  fpp_pkg::conv_t wr_data,
  input  logic           rd_en,
  output logic           not_empty,
  output fpp_pkg::conv_t rd_data,
  output logic [$clog2(DEPTH+1)-1:0] fill
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FW = $clog2(DEPTH + 1);
  fpp_pkg::conv_t mem [DEPTH];
  logic [AW-1:0] wp, rp;

  assign not_empty = (fill != '0);
  assign rd_data = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; fill <= '0;
    end else begin
      if (wr_en) wp <= (wp == AW'(DEPTH - 1)) ? '0 : wp + AW'(1);
      if (rd_en) rp <= (rp == AW'(DEPTH - 1)) ? '0 : rp + AW'(1);
      fill <= fill + FW'(wr_en) - FW'(rd_en);
    end
    if (wr_en) mem[wp] <= wr_data;
  end
endmodule

### rtl/fpp_emit.sv
// Back part: replays each converted word once per output channel.
`timescale 1ns / 1ps
module fpp_emit #(
  parameter int CW = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           avail,
  input  fpp_pkg::conv_t data,
  input  logic [CW-1:0]  nchan,
  output logic           take,
  output logic           strobe,
  output logic [31:0]    pcm_word,
  output logic [2:0]     byte_count,
  output logic           last_channel
);
  logic [CW-1:0] k;
  logic          last;
  assign last = (k + CW'(1) == nchan);
  assign take = avail && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      k <= '0; strobe <= 1'b0;
    end else begin
      strobe <= avail;
      if (avail) k <= last ? '0 : k + CW'(1);
    end
    pcm_word     <= data.word;
    byte_count   <= data.nbytes;
    last_channel <= last;
  end
endmodule
